### rtl/core/hvd_pkg.sv
// ----------------------------------------------------------------------------
// hvd_pkg
// shared constants, cordic arctangent table and fixed-point helpers for the
// haversine distance pipeline
// ----------------------------------------------------------------------------
package hvd_pkg;

    localparam int CORDIC_STEPS = 32;
    localparam int ZW = 36;
    localparam int XW = 44;

    localparam logic signed [XW-1:0] GAIN_Q40 = 44'sd667681663043;
    localparam logic [31:0] TURN_M_Q6 = 32'd2561931110;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [62:0] ONE_Q62 = 63'h4000_0000_0000_0000;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] t;
        unique case (i)
            5'd0: t = 32'h20000000;
            5'd1: t = 32'h12E4051E;
            5'd2: t = 32'h09FB385B;
            5'd3: t = 32'h051111D4;
            5'd4: t = 32'h028B0D43;
            5'd5: t = 32'h0145D7E1;
            5'd6: t = 32'h00A2F61E;
            5'd7: t = 32'h00517C55;
            5'd8: t = 32'h0028BE53;
            5'd9: t = 32'h00145F2F;
            5'd10: t = 32'h000A2F98;
            5'd11: t = 32'h000517CC;
            5'd12: t = 32'h00028BE6;
            5'd13: t = 32'h000145F3;
            5'd14: t = 32'h0000A2FA;
            5'd15: t = 32'h0000517D;
            5'd16: t = 32'h000028BE;
            5'd17: t = 32'h0000145F;
            5'd18: t = 32'h00000A30;
            5'd19: t = 32'h00000518;
            5'd20: t = 32'h0000028C;
            5'd21: t = 32'h00000146;
            5'd22: t = 32'h000000A3;
            5'd23: t = 32'h00000051;
            5'd24: t = 32'h00000029;
            5'd25: t = 32'h00000014;
            5'd26: t = 32'h0000000A;
            5'd27: t = 32'h00000005;
            5'd28: t = 32'h00000003;
            5'd29: t = 32'h00000001;
            5'd30: t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

    // q40 -> q31 magnitude clamped to [0, 2^31]
    function automatic logic [31:0] q31_mag(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] s;
        logic [XW-1:0] m;
        s = v >>> 9;
        m = s[XW-1] ? XW'(-s) : XW'(s);
        return (m > XW'(ONE_Q31)) ? ONE_Q31 : m[31:0];
    endfunction

    function automatic logic [31:0] q31_nonneg(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] s;
        s = v >>> 9;
        if (s[XW-1])
            return 32'd0;
        return (XW'(s) > XW'(ONE_Q31)) ? ONE_Q31 : s[31:0];
    endfunction

endpackage

### rtl/core/hvd_rot_stage.sv
// ----------------------------------------------------------------------------
// hvd_rot_stage
// one registered rotation-mode cordic micro-rotation (angles in 2^-33 turn)
// ----------------------------------------------------------------------------
module hvd_rot_stage #(
    parameter int STEP = 0
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [hvd_pkg::XW-1:0]    x_in,
    input  logic signed [hvd_pkg::XW-1:0]    y_in,
    input  logic signed [hvd_pkg::ZW-1:0]    z_in,
    output logic signed [hvd_pkg::XW-1:0]    x_out,
    output logic signed [hvd_pkg::XW-1:0]    y_out,
    output logic signed [hvd_pkg::ZW-1:0]    z_out
);
    import hvd_pkg::*;

    localparam logic signed [ZW-1:0] ANG = ZW'({atan_turn(5'(STEP)), 1'b0});

    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    always_comb
    begin
        if (!z_in[ZW-1])
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ANG;
        end
        else
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

### rtl/core/hvd_vec_stage.sv
// ----------------------------------------------------------------------------
// hvd_vec_stage
// one registered vectoring-mode cordic micro-rotation (angle in 2^-32 turn)
// ----------------------------------------------------------------------------
module hvd_vec_stage #(
    parameter int STEP = 0
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [hvd_pkg::XW-1:0]    x_in,
    input  logic signed [hvd_pkg::XW-1:0]    y_in,
    input  logic signed [hvd_pkg::ZW-1:0]    z_in,
    output logic signed [hvd_pkg::XW-1:0]    x_out,
    output logic signed [hvd_pkg::XW-1:0]    y_out,
    output logic signed [hvd_pkg::ZW-1:0]    z_out
);
    import hvd_pkg::*;

    localparam logic signed [ZW-1:0] ANG = ZW'(atan_turn(5'(STEP)));

    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    always_comb
    begin
        if (y_in > 0)
        begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ANG;
        end
        else
        begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

### rtl/core/hvd_isqrt.sv
// ----------------------------------------------------------------------------
// hvd_isqrt
// pipelined floor square root of a 63-bit value, one result bit per stage
// ----------------------------------------------------------------------------
module hvd_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [62:0] n_in,
    output logic [31:0] root
);
    localparam int NS = 32;

    logic [63:0] rem_reg [NS];
    logic [63:0] res_reg [NS];

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_bit
            localparam logic [63:0] BIT = 64'd1 << (2 * (NS - 1 - g));
            logic [63:0] rem_in, res_in, rem_next, res_next;
            if (g == 0)
            begin : g_first
                assign rem_in = {1'b0, n_in};
                assign res_in = 64'd0;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[g-1];
                assign res_in = res_reg[g-1];
            end
            always_comb
            begin
                if (rem_in >= res_in + BIT)
                begin
                    rem_next = rem_in - (res_in + BIT);
                    res_next = (res_in >> 1) + BIT;
                end
                else
                begin
                    rem_next = rem_in;
                    res_next = res_in >> 1;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= rem_next;
                    res_reg[g] <= res_next;
                end
            end
        end
    endgenerate

    assign root = res_reg[NS-1][31:0];
endmodule

### rtl/core/haversine_distance.sv
// ----------------------------------------------------------------------------
// haversine_distance
// great-circle distance in metres between two points on a 6371 km sphere
// ----------------------------------------------------------------------------
// usage:
//   the in channel carries a request of two points (lat_a, lon_a, lat_b,
//   lon_b), binary angles where 2^(ANGLE_BITS-1) is 180 degrees. a request
//   is taken when in_valid is high and in_stall low. the out channel gives
//   distance_m, rounded to the nearest metre, taken when out_valid is high
//   and out_stall low.
//   the datapath is one pipeline that advances as a whole: prep (2 stages),
//   four parallel 32-step rotation cordics, clamp, two multiply stages, sum
//   and clamp, two parallel 32-stage square roots, a 32-step vectoring
//   cordic, clamp, and a scaling multiply into the output register.
//   throughput is one request per cycle while the pipeline is not held; it
//   is set by every cordic and square-root step having its own register.
//   when out_stall is high with a result waiting, the whole pipeline holds;
//   in_stall is high exactly then, so nothing is lost or repeated.
//   reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module haversine_distance #(
    parameter int ANGLE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] lat_a,
    input  logic [31:0] lon_a,
    input  logic [31:0] lat_b,
    input  logic [31:0] lon_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [24:0] distance_m
);
    import hvd_pkg::*;

    localparam int DEPTH = 104;
    localparam int UP = (ANGLE_BITS >= 32) ? 0 : 32 - ANGLE_BITS;
    localparam int DN = (ANGLE_BITS >= 32) ? ANGLE_BITS - 32 : 0;
    localparam logic signed [49:0] LIM = 50'sd1 <<< (ANGLE_BITS - 2);

    // one enable for the whole pipe: stall only when result is stuck
    logic en;
    logic [DEPTH-1:0] vld_reg;
    assign en = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // ---------------- stage p0: latitude saturate, longitude difference
    logic signed [32:0] la0_reg, lb0_reg;
    logic [ANGLE_BITS-1:0] w0_reg;

    // the limit only bites when it fits the field, so 33 bits carry the result
    function automatic logic signed [32:0] sat_lat(input logic [31:0] raw);
        logic signed [49:0] v;
        v = 50'(signed'(raw));
        if (v > LIM) v = LIM;
        if (v < -LIM) v = -LIM;
        return 33'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la0_reg <= sat_lat(lat_a);
            lb0_reg <= sat_lat(lat_b);
            w0_reg  <= ANGLE_BITS'(33'(signed'(lon_b)) - 33'(signed'(lon_a)));
        end
    end

    // ---------------- stage p1: to 2^-32 turn, build cordic angles (2^-33)
    function automatic logic signed [ZW-1:0] to_turn(input logic signed [49:0] v);
        logic signed [49:0] t;
        t = (v <<< UP) >>> DN;
        return ZW'(t);
    endfunction

    logic signed [ZW-1:0] la_t, lb_t, dl_t;
    logic signed [ZW-1:0] zd_reg, zl_reg, za_reg, zb_reg;
    assign la_t = to_turn(50'(la0_reg));
    assign lb_t = to_turn(50'(lb0_reg));
    assign dl_t = to_turn(50'(signed'(w0_reg)));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zd_reg <= lb_t - la_t;
            zl_reg <= dl_t;
            za_reg <= la_t <<< 1;
            zb_reg <= lb_t <<< 1;
        end
    end

    // ---------------- four rotation cordics
    logic signed [XW-1:0] rx [4][CORDIC_STEPS+1];
    logic signed [XW-1:0] ry [4][CORDIC_STEPS+1];
    logic signed [ZW-1:0] rz [4][CORDIC_STEPS+1];

    assign rz[0][0] = zd_reg;
    assign rz[1][0] = zl_reg;
    assign rz[2][0] = za_reg;
    assign rz[3][0] = zb_reg;

    genvar r, k;
    generate
        for (r = 0; r < 4; r++)
        begin : g_rot
            assign rx[r][0] = GAIN_Q40;
            assign ry[r][0] = '0;
            for (k = 0; k < CORDIC_STEPS; k++)
            begin : g_step
                hvd_rot_stage #(.STEP(k)) u_stage (
                    .clk(clk), .en(en),
                    .x_in(rx[r][k]), .y_in(ry[r][k]), .z_in(rz[r][k]),
                    .x_out(rx[r][k+1]), .y_out(ry[r][k+1]), .z_out(rz[r][k+1])
                );
            end
        end
    endgenerate

    // ---------------- clamp to q31
    logic [31:0] s1_reg, s2_reg, ca_reg, cb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= q31_mag(ry[0][CORDIC_STEPS]);
            s2_reg <= q31_mag(ry[1][CORDIC_STEPS]);
            ca_reg <= q31_nonneg(rx[2][CORDIC_STEPS]);
            cb_reg <= q31_nonneg(rx[3][CORDIC_STEPS]);
        end
    end

    // ---------------- multiply 1: s1^2, ua, ub
    logic [63:0] ss_reg, pa, pb;
    logic [31:0] ua_reg, ub_reg;
    assign pa = 64'(ca_reg) * 64'(s2_reg);
    assign pb = 64'(cb_reg) * 64'(s2_reg);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss_reg <= 64'(s1_reg) * 64'(s1_reg);
            ua_reg <= pa[62:31];
            ub_reg <= pb[62:31];
        end
    end

    // ---------------- multiply 2: ua*ub
    logic [63:0] ss2_reg, uu_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ss2_reg <= ss_reg;
            uu_reg  <= 64'(ua_reg) * 64'(ub_reg);
        end
    end

    // ---------------- sum and clamp a
    logic [64:0] a_sum;
    logic [62:0] a_reg, ac_reg;
    assign a_sum = 65'(ss2_reg) + 65'(uu_reg);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= (a_sum > 65'(ONE_Q62)) ? ONE_Q62 : a_sum[62:0];
            ac_reg <= ONE_Q62 - ((a_sum > 65'(ONE_Q62)) ? ONE_Q62 : a_sum[62:0]);
        end
    end

    // ---------------- square roots
    logic [31:0] sa, sc;
    hvd_isqrt u_sqrt_a (.clk(clk), .en(en), .n_in(a_reg), .root(sa));
    hvd_isqrt u_sqrt_c (.clk(clk), .en(en), .n_in(ac_reg), .root(sc));

    // ---------------- vectoring cordic
    logic signed [XW-1:0] vx [CORDIC_STEPS+1];
    logic signed [XW-1:0] vy [CORDIC_STEPS+1];
    logic signed [ZW-1:0] vz [CORDIC_STEPS+1];
    assign vx[0] = XW'(sc);
    assign vy[0] = XW'(sa);
    assign vz[0] = '0;

    generate
        for (k = 0; k < CORDIC_STEPS; k++)
        begin : g_vec
            hvd_vec_stage #(.STEP(k)) u_stage (
                .clk(clk), .en(en),
                .x_in(vx[k]), .y_in(vy[k]), .z_in(vz[k]),
                .x_out(vx[k+1]), .y_out(vy[k+1]), .z_out(vz[k+1])
            );
        end
    endgenerate

    // ---------------- clamp angle to [0, 2^30]
    logic [30:0] ang_reg;
    logic signed [ZW-1:0] zf;
    assign zf = vz[CORDIC_STEPS];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zf[ZW-1])
                ang_reg <= '0;
            else if (zf > (ZW'(1) <<< 30))
                ang_reg <= 31'h4000_0000;
            else
                ang_reg <= zf[30:0];
        end
    end

    // ---------------- scale to metres
    logic [63:0] dist_full;
    logic [24:0] dist_reg;
    assign dist_full = 64'(ang_reg) * 64'(TURN_M_Q6) + (64'd1 << 36);
    always_ff @(posedge clk)
    begin
        if (en)
            dist_reg <= dist_full[61:37];
    end
    assign distance_m = dist_reg;

`ifndef SYNTHESIS
    // a stuck result holds the whole pipe
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance_m))
        else $error("stalled result changed");
    // input stall only while a result is stuck
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall mismatch");
    // result never beyond half circumference
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_m <= 25'd20015087)
        else $error("distance out of range");
`endif
endmodule
